/* hdl/ppe_pkg.sv */
package ppe_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ADDR_BYTE = 8'hFF;
    localparam logic [7:0] CTRL_BYTE = 8'h03;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] TAIL_BYTE = 8'h00;

    localparam logic [15:0] PROTOCOL_ID_RESET = 16'h0021;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       frame_end;
    } out_beat_t;

endpackage

/* hdl/ppe_in_reg.sv */
module ppe_in_reg
    import ppe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_payload,
    input  logic     pop,
    output logic     cur_valid,
    output in_beat_t cur_item
);

    logic     valid_reg;
    logic     valid_next;
    in_beat_t item_reg;

    assign s_ready   = !valid_reg || pop;
    assign cur_valid = valid_reg;
    assign cur_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_payload;
        end
    end

endmodule

/* hdl/ppe_emitter.sv */
module ppe_emitter
    import ppe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cur_valid,
    input  in_beat_t    cur_item,
    input  logic [15:0] protocol_id,
    input  logic        out_free,
    output logic        emit_valid,
    output out_beat_t   emit_beat,
    output logic        pop
);

    localparam logic [3:0] P_FLAG_OPEN  = 4'd0;
    localparam logic [3:0] P_ADDR       = 4'd1;
    localparam logic [3:0] P_CTRL       = 4'd2;
    localparam logic [3:0] P_PROTO_HI   = 4'd3;
    localparam logic [3:0] P_PROTO_LO   = 4'd4;
    localparam logic [3:0] P_ESC        = 4'd5;
    localparam logic [3:0] P_DATA       = 4'd6;
    localparam logic [3:0] P_CK_HI      = 4'd7;
    localparam logic [3:0] P_CK_LO      = 4'd8;
    localparam logic [3:0] P_TAIL       = 4'd9;
    localparam logic [3:0] P_FLAG_CLOSE = 4'd10;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic        started_reg;
    logic        started_next;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic        odd_reg;
    logic        odd_next;
    logic [7:0]  pend_reg;
    logic [7:0]  pend_next;

    logic        special;
    logic [3:0]  start_phase;
    logic [3:0]  phase;
    logic        out_load;
    logic        summed;
    logic        run_end;
    logic [7:0]  byte_sel;
    logic [15:0] ck_full;

    assign special     = (cur_item.payload_byte == FLAG_BYTE) ||
                         (cur_item.payload_byte == ESC_BYTE);
    assign start_phase = in_frame_reg ? (special ? P_ESC : P_DATA) : P_FLAG_OPEN;
    assign phase       = started_reg ? phase_reg : start_phase;
    assign out_load    = cur_valid && out_free;
    assign ck_full     = odd_reg ? oc_add(sum_reg, {pend_reg, 8'h00}) : sum_reg;

    always_comb begin
        byte_sel   = TAIL_BYTE;
        phase_next = phase;
        summed     = 1'b0;
        run_end    = 1'b0;
        case (phase)
            P_FLAG_OPEN: begin
                byte_sel   = FLAG_BYTE;
                phase_next = P_ADDR;
            end
            P_ADDR: begin
                byte_sel   = ADDR_BYTE;
                summed     = 1'b1;
                phase_next = P_CTRL;
            end
            P_CTRL: begin
                byte_sel   = CTRL_BYTE;
                summed     = 1'b1;
                phase_next = P_PROTO_HI;
            end
            P_PROTO_HI: begin
                byte_sel   = protocol_id[15:8];
                summed     = 1'b1;
                phase_next = P_PROTO_LO;
            end
            P_PROTO_LO: begin
                byte_sel   = protocol_id[7:0];
                summed     = 1'b1;
                phase_next = special ? P_ESC : P_DATA;
            end
            P_ESC: begin
                byte_sel   = ESC_BYTE;
                summed     = 1'b1;
                phase_next = P_DATA;
            end
            P_DATA: begin
                byte_sel   = cur_item.payload_byte;
                summed     = 1'b1;
                phase_next = P_CK_HI;
                run_end    = !cur_item.last_byte;
            end
            P_CK_HI: begin
                byte_sel   = ~ck_full[15:8];
                phase_next = P_CK_LO;
            end
            P_CK_LO: begin
                byte_sel   = ~sum_reg[7:0];
                phase_next = P_TAIL;
            end
            P_TAIL: begin
                byte_sel   = TAIL_BYTE;
                phase_next = P_FLAG_CLOSE;
            end
            P_FLAG_CLOSE: begin
                byte_sel   = FLAG_BYTE;
                run_end    = 1'b1;
            end
            default: begin
                byte_sel   = TAIL_BYTE;
                phase_next = P_FLAG_OPEN;
            end
        endcase
    end

    assign emit_valid          = cur_valid;
    assign emit_beat.out_byte  = byte_sel;
    assign emit_beat.run_end   = run_end;
    assign emit_beat.frame_end = (phase == P_FLAG_CLOSE);
    assign pop                 = out_load && run_end;

    always_comb begin
        started_next  = started_reg;
        in_frame_next = in_frame_reg;
        sum_next      = sum_reg;
        odd_next      = odd_reg;
        pend_next     = pend_reg;
        if (out_load) begin
            started_next = !run_end;
            if (summed) begin
                if (!odd_reg) begin
                    pend_next = byte_sel;
                    odd_next  = 1'b1;
                end else begin
                    sum_next  = oc_add(sum_reg, {pend_reg, byte_sel});
                    pend_next = 8'h00;
                    odd_next  = 1'b0;
                end
            end
            if (phase == P_FLAG_OPEN) begin
                in_frame_next = 1'b1;
                sum_next      = 16'h0000;
                odd_next      = 1'b0;
                pend_next     = 8'h00;
            end
            if (phase == P_CK_HI) begin
                sum_next  = ck_full;
                odd_next  = 1'b0;
                pend_next = 8'h00;
            end
            if (phase == P_FLAG_CLOSE) begin
                in_frame_next = 1'b0;
                sum_next      = 16'h0000;
                odd_next      = 1'b0;
                pend_next     = 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            in_frame_reg <= 1'b0;
            sum_reg      <= 16'h0000;
            odd_reg      <= 1'b0;
            pend_reg     <= 8'h00;
        end else begin
            started_reg  <= started_next;
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
            odd_reg      <= odd_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            phase_reg <= phase_next;
        end
    end

    a_close_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid && phase == P_FLAG_CLOSE) |-> run_end)
        else $error("closing flag not marked as end of run");

    a_open_sets_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && phase == P_FLAG_OPEN) |=> in_frame_reg)
        else $error("frame not open after opening flag");

    a_close_clears_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && phase == P_FLAG_CLOSE) |=>
        (!in_frame_reg && !odd_reg && sum_reg == 16'h0000))
        else $error("checksum state not cleared after closing flag");

    a_ck_lo_even: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid && phase == P_CK_LO) |-> !odd_reg)
        else $error("odd byte left unpadded at checksum");

    a_header_only_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid && !started_reg && in_frame_reg) |-> (phase != P_FLAG_OPEN))
        else $error("header started inside an open frame");

endmodule

/* hdl/ppe_out_reg.sv */
module ppe_out_reg
    import ppe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      emit_valid,
    input  out_beat_t emit_beat,
    output logic      out_free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_payload
);

    logic      valid_reg;
    logic      valid_next;
    out_beat_t beat_reg;

    assign out_free  = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_payload = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = emit_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && emit_valid) begin
            beat_reg <= emit_beat;
        end
    end

endmodule

/* hdl/ppp_style_frame_encoder.sv */
// Framer for a byte stream: each input beat is one payload byte plus a last-byte
// flag. The first byte of a frame is preceded by 7E FF 03 and the protocol id
// (high byte first); payload bytes 7E and 7D go out as 7D followed by the byte
// unchanged; the last byte is followed by the inverted 16-bit ones' complement
// checksum of everything from the address byte through the stuffed payload,
// a 00 tail and a closing 7E. One output byte leaves per cycle unless m_ready stalls;
// an input beat produces 1 or 2 bytes mid-frame (2 for an escaped byte), plus
// 5 header bytes and 4 trailer bytes. The next input beat is taken in the cycle
// the current one emits its last byte, so unescaped mid-frame beats stream back
// to back. protocol_id is sampled as the header goes out; write it only while no
// beat is in flight.
module ppp_style_frame_encoder
    import ppe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_payload,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] protocol_id_reg;
    logic        pop;
    logic        cur_valid;
    in_beat_t    cur_item;
    logic        out_free;
    logic        emit_valid;
    out_beat_t   emit_beat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            protocol_id_reg <= PROTOCOL_ID_RESET;
        end else if (cfg_valid && cfg_ready) begin
            protocol_id_reg <= cfg_data;
        end
    end

    ppe_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .pop       (pop),
        .cur_valid (cur_valid),
        .cur_item  (cur_item)
    );

    ppe_emitter u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cur_valid   (cur_valid),
        .cur_item    (cur_item),
        .protocol_id (protocol_id_reg),
        .out_free    (out_free),
        .emit_valid  (emit_valid),
        .emit_beat   (emit_beat),
        .pop         (pop)
    );

    ppe_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit_valid (emit_valid),
        .emit_beat  (emit_beat),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule
